### rtl/core/ars_pkg.sv
// ----------------------------------------------------------------------------
// ars_pkg
// Types and constants shared by the roulette selector cells, the blend stage
// and the top level.
// ----------------------------------------------------------------------------
package ars_pkg;

    localparam int SCORE_W = 32;
    localparam int COUNT_W = 16;
    localparam int OP_W    = 3;
    localparam int IDX_W   = 4;
    localparam int CFG_W   = 5;
    localparam int FRAC_W  = 32;

    typedef logic [SCORE_W-1:0] t_score;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [OP_W-1:0]    t_op;

    // blend weights in q0.16
    localparam logic [15:0] KEEP_Q16    = 16'd52429;
    localparam logic [15:0] ERODE_Q16   = 16'd13107;
    localparam int          BLEND_SHIFT = 16;

    localparam t_score SCORE_MAX = '1;
    localparam t_count COUNT_MAX = '1;

    localparam logic [CFG_W-1:0] ITEMS_IN_USE_RST = 5'd16;

    // request op codes
    localparam t_op OP_LOAD     = 3'd0;
    localparam t_op OP_MARK     = 3'd1;
    localparam t_op OP_SELECT   = 3'd2;
    localparam t_op OP_UPDATE   = 3'd3;
    localparam t_op OP_NEWROUND = 3'd4;

    // what the blend stage does to the entry passing through
    typedef enum logic [2:0] {
        PK_PASS,
        PK_LOAD,
        PK_MARK,
        PK_SELECT,
        PK_UPDATE,
        PK_NEWROUND
    } t_proc_kind;

    typedef struct packed {
        t_score base_score;
        t_score live_score;
        logic   selectable;
        t_count selection_count;
        t_count success_count;
    } t_entry;

    typedef struct packed {
        t_proc_kind kind;
        logic       hit;
        logic       success;
        logic       still;
        t_score     score;
    } t_proc_ctl;

endpackage

### rtl/core/ars_cell.sv
// ----------------------------------------------------------------------------
// ars_cell
// One slot of the entry ring: holds an entry and takes its neighbor's entry
// whenever the ring rotates.
// ----------------------------------------------------------------------------
module ars_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  ars_pkg::t_entry i_entry,
    output ars_pkg::t_entry o_entry
);
    import ars_pkg::*;

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

### rtl/core/ars_proc.sv
// ----------------------------------------------------------------------------
// ars_proc
// Blend stage of the entry ring: multiplies at the head, registers the
// products with the entry, then finishes the update on the way to the tail.
// ----------------------------------------------------------------------------
module ars_proc #(
    parameter int SCORE_FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_shift,
    input  ars_pkg::t_entry    i_entry,
    input  ars_pkg::t_proc_ctl i_ctl,
    output ars_pkg::t_entry    o_entry
);
    import ars_pkg::*;

    localparam int KEEP_W  = SCORE_W + 16;
    localparam int ERODE_W = COUNT_W + 14;
    localparam int ERSH_W  = ERODE_W + SCORE_FRAC_BITS;
    localparam int ACC_W   = ((ERSH_W > KEEP_W) ? ERSH_W : KEEP_W) + 1;
    localparam int V_W     = ACC_W - BLEND_SHIFT;

    t_score              mul_old;
    t_count              mul_extra;
    logic [KEEP_W-1:0]   keep_prod;
    logic [ERODE_W-1:0]  erode_prod;

    t_entry              r_entry;
    t_proc_ctl           r_ctl;
    logic [KEEP_W-1:0]   r_keep;
    logic [ERODE_W-1:0]  r_erode;

    logic [ACC_W-1:0]    acc;
    logic [V_W-1:0]      blend_v;
    t_score              blended;
    t_score              new_round;
    t_entry              res;

    // new round blends the round score toward the success count,
    // update blends the current score toward the success bit
    always_comb begin
        if (i_ctl.kind == PK_NEWROUND) begin
            mul_old   = i_entry.base_score;
            mul_extra = i_entry.success_count;
        end else begin
            mul_old   = i_entry.live_score;
            mul_extra = COUNT_W'(i_ctl.success);
        end
    end

    assign keep_prod  = KEEP_W'(mul_old) * KEEP_W'(KEEP_Q16);
    assign erode_prod = ERODE_W'(ERODE_W'(mul_extra) * ERODE_W'(ERODE_Q16));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
            r_ctl   <= '0;
            r_keep  <= '0;
            r_erode <= '0;
        end else if (i_shift) begin
            r_entry <= i_entry;
            r_ctl   <= i_ctl;
            r_keep  <= keep_prod;
            r_erode <= erode_prod;
        end
    end

    always_comb begin
        acc     = ACC_W'(r_keep) + (ACC_W'(r_erode) << SCORE_FRAC_BITS);
        blend_v = acc[ACC_W-1:BLEND_SHIFT];
        if (blend_v > V_W'(SCORE_MAX)) begin
            blended = SCORE_MAX;
        end else if (blend_v == '0) begin
            blended = SCORE_W'(1);
        end else begin
            blended = blend_v[SCORE_W-1:0];
        end
    end

    assign new_round = (r_entry.selection_count != '0) ? blended : r_entry.base_score;

    always_comb begin
        res = r_entry;
        case (r_ctl.kind)
            PK_LOAD: begin
                if (r_ctl.hit) begin
                    res.base_score      = r_ctl.score;
                    res.live_score      = r_ctl.score;
                    res.selectable      = 1'b1;
                    res.selection_count = '0;
                    res.success_count   = '0;
                end
            end
            PK_MARK: begin
                if (r_ctl.hit) begin
                    res.selectable = 1'b0;
                end
            end
            PK_SELECT: begin
                if (r_ctl.hit && r_entry.selection_count != COUNT_MAX) begin
                    res.selection_count = r_entry.selection_count + 1'b1;
                end
            end
            PK_UPDATE: begin
                if (r_ctl.hit) begin
                    if (r_ctl.success && r_entry.success_count != COUNT_MAX) begin
                        res.success_count = r_entry.success_count + 1'b1;
                    end
                    res.selectable = r_ctl.still;
                    res.live_score = blended;
                end
            end
            PK_NEWROUND: begin
                if (r_ctl.hit) begin
                    res.base_score      = new_round;
                    res.live_score      = new_round;
                    res.selectable      = 1'b1;
                    res.selection_count = '0;
                    res.success_count   = '0;
                end
            end
            default: begin
                res = r_entry;
            end
        endcase
    end

    assign o_entry = res;

endmodule

### rtl/core/adaptive_roulette_selector.sv
// ----------------------------------------------------------------------------
// adaptive_roulette_selector
// Weighted random selector with decaying scores; the entries sit in a ring of
// cells that rotates once through a shared blend stage for each pass.
// ----------------------------------------------------------------------------
// sequence: load, mark, update and new round run one sweep pass and then the result state;
//   select runs a sum pass, a threshold multiply (S_THR1, then S_THR2) and a scan pass;
//   an unused op, or an update with no valid choice, goes straight to the result state
// throughput: one request at a time; while a pass runs, the ring takes one step per cycle
//   through the single blend stage
// reset: all entries clear, no choice is valid, items_in_use returns to 16
// ----------------------------------------------------------------------------
module adaptive_roulette_selector #(
    parameter int ITEMS           = 16,
    parameter int SCORE_FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_we,
    input  logic [ars_pkg::CFG_W-1:0] i_cfg_wdata,
    // request channel
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  ars_pkg::t_op           i_op,
    input  logic [ars_pkg::IDX_W-1:0] i_item_index,
    input  ars_pkg::t_score        i_initial_score,
    input  logic [ars_pkg::FRAC_W-1:0] i_random_fraction,
    input  logic                   i_success,
    input  logic                   i_still_selectable,
    // result channel
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_found,
    output logic [ars_pkg::IDX_W-1:0] o_chosen_item
);
    import ars_pkg::*;

    localparam int CNT_W = $clog2(ITEMS + 1);
    localparam int LC_W  = $clog2(ITEMS);
    localparam int SUM_W = SCORE_W + $clog2(ITEMS);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int IXC_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SUM   = 3'd1;
    localparam logic [2:0] S_THR1  = 3'd2;
    localparam logic [2:0] S_THR2  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_SWEEP = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_k;
    t_op                 r_op;
    logic [IDX_W-1:0]    r_idx;
    t_score              r_score;
    logic [FRAC_W-1:0]   r_frac;
    logic                r_succ;
    logic                r_still;
    logic [CFG_W-1:0]    r_items;
    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    r_run;
    logic [SUM_W-1:0]    r_thr;
    logic [63:0]         r_plo;
    logic [SUM_W-1:0]    r_phi;
    logic                r_found;
    logic [LC_W-1:0]     r_last;
    logic                r_last_valid;
    logic                r_out_valid;
    logic                r_out_found;
    logic [IDX_W-1:0]    r_out_chosen;

    t_entry              cell_q [ITEMS];
    t_entry              proc_out;
    t_proc_ctl           ctl;
    t_entry              head;
    logic                shift;
    logic                accept;
    logic                can_push;
    logic                last_step;
    logic                k_lt_items;
    logic                in_use;
    logic                idx_hit;
    logic                last_hit;
    t_score              head_w;
    logic [SUM_W-1:0]    run_nxt;
    logic                sel_hit;
    logic [LC_W+IDX_W-1:0] chosen_ext;

    // ring of entry cells, the blend stage closes it from head to tail
    for (genvar g = 0; g < ITEMS; g++) begin : g_cell
        t_entry nxt;
        if (g == ITEMS - 1) begin : g_tail
            assign nxt = proc_out;
        end else begin : g_mid
            assign nxt = cell_q[g+1];
        end
        ars_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_entry (nxt),
            .o_entry (cell_q[g])
        );
    end

    ars_proc #(
        .SCORE_FRAC_BITS (SCORE_FRAC_BITS)
    ) u_proc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (shift),
        .i_entry (head),
        .i_ctl   (ctl),
        .o_entry (proc_out)
    );

    assign head       = cell_q[0];
    assign shift      = (r_state == S_SUM) || (r_state == S_SCAN) || (r_state == S_SWEEP);
    assign last_step  = (r_k == CNT_W'(ITEMS));
    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign can_push   = !r_out_valid || !i_out_stall;

    // head entry index equals the pass step while it is below ITEMS
    assign k_lt_items = (r_k < CNT_W'(ITEMS));
    assign in_use     = (CMP_W'(r_k) < CMP_W'(r_items));
    assign idx_hit    = (IXC_W'(r_k) == IXC_W'(r_idx));
    assign last_hit   = (r_k == CNT_W'(r_last));
    assign head_w     = (head.selectable && in_use && k_lt_items) ? head.live_score : '0;
    assign run_nxt    = r_run + SUM_W'(head_w);
    assign sel_hit    = (r_state == S_SCAN) && k_lt_items && in_use && !r_found
                        && (run_nxt > r_thr);

    always_comb begin
        ctl.kind    = PK_PASS;
        ctl.hit     = 1'b0;
        ctl.success = r_succ;
        ctl.still   = r_still;
        ctl.score   = r_score;
        if (r_state == S_SCAN) begin
            ctl.kind = PK_SELECT;
            ctl.hit  = sel_hit;
        end else if (r_state == S_SWEEP && k_lt_items) begin
            case (r_op)
                OP_LOAD: begin
                    ctl.kind = PK_LOAD;
                    ctl.hit  = idx_hit;
                end
                OP_MARK: begin
                    ctl.kind = PK_MARK;
                    ctl.hit  = idx_hit;
                end
                OP_UPDATE: begin
                    ctl.kind = PK_UPDATE;
                    ctl.hit  = last_hit && r_last_valid;
                end
                OP_NEWROUND: begin
                    ctl.kind = PK_NEWROUND;
                    ctl.hit  = 1'b1;
                end
                default: begin
                    ctl.kind = PK_PASS;
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_op)
                        OP_LOAD, OP_MARK, OP_NEWROUND: n_state = S_SWEEP;
                        OP_SELECT:                     n_state = S_SUM;
                        OP_UPDATE: n_state = r_last_valid ? S_SWEEP : S_OUT;
                        default:                       n_state = S_OUT;
                    endcase
                end
            end
            S_SUM:   n_state = last_step ? S_THR1 : S_SUM;
            S_THR1:  n_state = S_THR2;
            S_THR2:  n_state = S_SCAN;
            S_SCAN:  n_state = last_step ? S_OUT : S_SCAN;
            S_SWEEP: n_state = last_step ? S_OUT : S_SWEEP;
            S_OUT:   n_state = can_push ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_k          <= '0;
            r_items      <= ITEMS_IN_USE_RST;
            r_found      <= 1'b0;
            r_last       <= '0;
            r_last_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_items <= i_cfg_wdata;
            end
            if (shift) begin
                r_k <= last_step ? '0 : r_k + 1'b1;
            end
            if (accept) begin
                r_found <= 1'b0;
            end
            if (r_state == S_THR2) begin
                r_last_valid <= 1'b0;
            end
            if (sel_hit) begin
                r_found      <= 1'b1;
                r_last       <= LC_W'(r_k);
                r_last_valid <= 1'b1;
            end
            if (r_state == S_OUT && can_push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign chosen_ext = (LC_W + IDX_W)'(r_last);

    // request fields, sums and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_op;
            r_idx   <= i_item_index;
            r_score <= i_initial_score;
            r_frac  <= i_random_fraction;
            r_succ  <= i_success;
            r_still <= i_still_selectable;
            r_sum   <= '0;
        end
        if (r_state == S_SUM) begin
            r_sum <= r_sum + SUM_W'(head_w);
        end
        // threshold = floor(sum * frac / 2^32), split at bit 32 of the sum
        if (r_state == S_THR1) begin
            r_plo <= 64'(r_sum[SCORE_W-1:0]) * 64'(r_frac);
            r_phi <= SUM_W'(SUM_W'(r_sum[SUM_W-1:SCORE_W]) * SUM_W'(r_frac));
        end
        if (r_state == S_THR2) begin
            r_thr <= r_phi + SUM_W'(r_plo[63:32]);
            r_run <= '0;
        end
        if (r_state == S_SCAN) begin
            r_run <= run_nxt;
        end
        if (r_state == S_OUT && can_push) begin
            r_out_found  <= r_found && (r_op == OP_SELECT);
            r_out_chosen <= r_last_valid ? chosen_ext[IDX_W-1:0] : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_out_found;
    assign o_chosen_item = r_out_chosen;

    // a found entry always leaves a valid choice behind
    a_found_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> r_last_valid)
        else $error("found without a valid choice");

    // a sum pass ends on its last step and moves on to the threshold multiply
    a_sum_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) && last_step |=> (r_state == S_THR1))
        else $error("sum pass did not end on its last step");

    // results come only out of the result state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result raised outside the result state");

    // the ring only rotates while the counter runs through a pass
    a_ring_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_k == '0))
        else $error("pass counter not at rest while idle");

endmodule
